// ===== rtl/midi_track_event_parser_top_defines.svh =====
// Assertion macros for the MIDI track event parser.
// Included by midi_track_event_parser_top.sv; depends on nothing else.
`ifndef MIDI_TRACK_EVENT_PARSER_TOP_DEFINES_SVH
`define MIDI_TRACK_EVENT_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MTEP_ASSERT_NOW(label, clk_s, rstn_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MTEP_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mtep_pkg.sv =====
// Types and constants for the MIDI track event parser.
// Used by midi_track_event_parser_top.sv; depends on nothing.
package mtep_pkg;

    // Parser phase within one track event.
    typedef enum logic [3:0] {
        PH_DELTA,
        PH_STATUS,
        PH_META_TYPE,
        PH_META_LEN,
        PH_SYSEX_LEN,
        PH_SKIP,
        PH_DATA1,
        PH_DATA2,
        PH_HALT
    } phase_t;

    // Kind of a result transfer.
    typedef enum logic [1:0] {
        KIND_NOTE,
        KIND_TEMPO,
        KIND_NO_RUNNING,
        KIND_UNSUPPORTED
    } kind_t;

    // Status bytes and status classes.
    localparam logic [7:0] ST_META        = 8'hff;
    localparam logic [7:0] ST_SYSEX       = 8'hf0;
    localparam logic [7:0] ST_SYSEX_ESC   = 8'hf7;
    localparam logic [3:0] CLS_NOTE_OFF   = 4'h8;
    localparam logic [3:0] CLS_NOTE_ON    = 4'h9;
    localparam logic [3:0] CLS_CONTROL    = 4'hb;
    localparam logic [3:0] CLS_PROGRAM    = 4'hc;
    localparam logic [3:0] CLS_PRESSURE   = 4'hd;
    localparam logic [3:0] CLS_SYSTEM     = 4'hf;

    // Meta type of Set Tempo, its payload length, and the bank select controllers.
    localparam logic [7:0]  META_TEMPO    = 8'h51;
    localparam logic [31:0] TEMPO_LEN     = 32'd3;
    localparam logic [7:0]  CTRL_BANK_MSB = 8'd0;
    localparam logic [7:0]  CTRL_BANK_LSB = 8'd32;

    // One result item.
    typedef struct packed {
        kind_t        kind;
        logic [31:0]  tick;
        logic [7:0]   note;
        logic [7:0]   velocity;
        logic         note_on;
        logic [3:0]   channel;
        logic [7:0]   program_num;
        logic [14:0]  bank;
        logic [23:0]  tempo;
    } result_t;

endpackage

// ===== rtl/midi_track_event_parser_top.sv =====
// MIDI track event parser, top level; uses mtep_pkg and the assertion macros
// in midi_track_event_parser_top_defines.svh.
//
// Usage: the slave channel carries the body bytes of a standard MIDI file
// track, one byte per transfer in s_tdata, with s_tuser high on the first
// byte of a track; that byte clears tick, running status and the per-channel
// program and bank latches before it is parsed. The master channel carries
// at most one result per byte: note on/off events with tick, channel,
// program and bank, Set Tempo values, or an error kind after which bytes are
// ignored until the next track start.
// Each result is registered in the output register or, while that waits, in
// the skid register. Throughput: one byte per cycle unless s_tready is low;
// the whole parse step is one pass of logic between the state registers and
// the output register. Stalls: an output register and a skid register hold
// up to two results, so a byte is taken in the cycle a result waits;
// s_tready falls only when both are full. After reset the parser expects a
// delta time at tick zero and both output registers are empty.

`include "midi_track_event_parser_top_defines.svh"

module midi_track_event_parser_top
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte
    input  logic [0:0]   s_tuser,   // track_start
    output logic         m_tvalid,
    input  logic         m_tready,
    // event_tick, note_number, note_velocity, note_on, midi_channel,
    // program_number, bank_number, quarter_note_us, zero fill
    output logic [103:0] m_tdata,
    output logic [1:0]   m_tuser    // event_kind
);

    // Parser state.
    mtep_pkg::phase_t phase_reg, phase_next;
    logic [31:0] tick_reg, tick_next;
    logic [31:0] varlen_reg, varlen_next;
    logic [7:0]  last_status_reg, last_status_next;
    logic        last_valid_reg, last_valid_next;
    logic [7:0]  cur_status_reg, cur_status_next;
    logic [7:0]  first_data_reg, first_data_next;
    logic [7:0]  meta_type_reg, meta_type_next;
    logic [31:0] skip_reg, skip_next;
    logic [23:0] tempo_reg, tempo_next;
    logic        tempo_on_reg, tempo_on_next;

    // Per-channel latches.
    logic [7:0] prog_reg [16];
    logic [7:0] bank_hi_reg [16];
    logic [7:0] bank_lo_reg [16];

    // Output register and skid register.
    mtep_pkg::result_t out_reg, out_next, skid_reg, skid_next;
    logic out_valid_reg, out_valid_next, skid_valid_reg, skid_valid_next;

    logic        accept, start;
    logic [7:0]  b;
    mtep_pkg::phase_t phase_c;
    logic [31:0] tick_c, varlen_c;
    logic        last_valid_c, tempo_on_c;

    // Step results.
    logic              res_valid;
    mtep_pkg::result_t res;
    logic              prog_we, bank_hi_we, bank_lo_we;
    logic [3:0]        wr_ch;

    // Helpers inside the step.
    logic        do_len, len_meta, do_d1, running;
    logic [7:0]  d1_status, st;
    logic [31:0] acc, len_acc;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign start    = s_tuser[0];
    assign b        = s_tdata;

    // A track start returns the state to its reset values before the byte is parsed.
    assign phase_c      = start ? mtep_pkg::PH_DELTA : phase_reg;
    assign tick_c       = start ? 32'd0 : tick_reg;
    assign varlen_c     = start ? 32'd0 : varlen_reg;
    assign last_valid_c = start ? 1'b0 : last_valid_reg;
    assign tempo_on_c   = start ? 1'b0 : tempo_on_reg;

    // One parse step for the byte on the slave channel.
    always_comb
    begin
        phase_next       = phase_c;
        tick_next        = tick_c;
        varlen_next      = varlen_c;
        last_status_next = start ? 8'd0 : last_status_reg;
        last_valid_next  = last_valid_c;
        cur_status_next  = start ? 8'd0 : cur_status_reg;
        first_data_next  = start ? 8'd0 : first_data_reg;
        meta_type_next   = start ? 8'd0 : meta_type_reg;
        skip_next        = start ? 32'd0 : skip_reg;
        tempo_next       = start ? 24'd0 : tempo_reg;
        tempo_on_next    = tempo_on_c;
        res_valid        = 1'b0;
        res              = '0;
        res.tick         = tick_c;
        prog_we          = 1'b0;
        bank_hi_we       = 1'b0;
        bank_lo_we       = 1'b0;
        wr_ch            = cur_status_reg[3:0];
        do_len           = 1'b0;
        len_meta         = 1'b0;
        do_d1            = 1'b0;
        d1_status        = cur_status_reg;
        running          = !b[7];
        st               = last_status_reg;
        acc              = {varlen_c[24:0], b[6:0]};
        len_acc          = 32'd0;

        case (phase_c)
            mtep_pkg::PH_DELTA:
            begin
                if (b[7])
                begin
                    varlen_next = acc;
                end
                else
                begin
                    tick_next   = tick_c + acc;
                    varlen_next = 32'd0;
                    phase_next  = mtep_pkg::PH_STATUS;
                end
            end
            mtep_pkg::PH_STATUS:
            begin
                if (!running)
                begin
                    last_status_next = b;
                    last_valid_next  = 1'b1;
                    st               = b;
                end
                if (running && !last_valid_c)
                begin
                    phase_next = mtep_pkg::PH_HALT;
                    res_valid  = 1'b1;
                    res.kind   = mtep_pkg::KIND_NO_RUNNING;
                end
                else
                begin
                    cur_status_next = st;
                    if (st == mtep_pkg::ST_META)
                    begin
                        varlen_next = 32'd0;
                        if (running)
                        begin
                            meta_type_next = b;
                            phase_next     = mtep_pkg::PH_META_LEN;
                        end
                        else
                        begin
                            phase_next = mtep_pkg::PH_META_TYPE;
                        end
                    end
                    else if (st == mtep_pkg::ST_SYSEX || st == mtep_pkg::ST_SYSEX_ESC)
                    begin
                        varlen_next    = 32'd0;
                        meta_type_next = 8'd0;
                        phase_next     = mtep_pkg::PH_SYSEX_LEN;
                        do_len         = running;
                    end
                    else if (st[7:4] == mtep_pkg::CLS_SYSTEM)
                    begin
                        phase_next = mtep_pkg::PH_HALT;
                        res_valid  = 1'b1;
                        res.kind   = mtep_pkg::KIND_UNSUPPORTED;
                    end
                    else if (running)
                    begin
                        do_d1     = 1'b1;
                        d1_status = st;
                    end
                    else
                    begin
                        phase_next = mtep_pkg::PH_DATA1;
                    end
                end
            end
            mtep_pkg::PH_META_TYPE:
            begin
                meta_type_next = b;
                varlen_next    = 32'd0;
                phase_next     = mtep_pkg::PH_META_LEN;
            end
            mtep_pkg::PH_META_LEN:
            begin
                do_len   = 1'b1;
                len_meta = 1'b1;
            end
            mtep_pkg::PH_SYSEX_LEN:
            begin
                do_len = 1'b1;
            end
            mtep_pkg::PH_SKIP:
            begin
                if (tempo_on_c)
                begin
                    tempo_next = {tempo_reg[15:0], b};
                end
                skip_next = skip_reg - 32'd1;
                if (skip_next == 32'd0)
                begin
                    phase_next = mtep_pkg::PH_DELTA;
                    if (tempo_on_c)
                    begin
                        tempo_on_next = 1'b0;
                        res_valid     = 1'b1;
                        res.kind      = mtep_pkg::KIND_TEMPO;
                        res.tempo     = tempo_next;
                    end
                end
            end
            mtep_pkg::PH_DATA1:
            begin
                do_d1 = 1'b1;
            end
            mtep_pkg::PH_DATA2:
            begin
                phase_next = mtep_pkg::PH_DELTA;
                if (cur_status_reg[7:4] == mtep_pkg::CLS_NOTE_OFF ||
                    cur_status_reg[7:4] == mtep_pkg::CLS_NOTE_ON)
                begin
                    res_valid       = 1'b1;
                    res.kind        = mtep_pkg::KIND_NOTE;
                    res.note        = first_data_reg;
                    res.velocity    = b;
                    res.note_on     = (cur_status_reg[7:4] == mtep_pkg::CLS_NOTE_ON) &&
                                      (b != 8'd0);
                    res.channel     = cur_status_reg[3:0];
                    res.program_num = prog_reg[cur_status_reg[3:0]];
                    res.bank        = {bank_hi_reg[cur_status_reg[3:0]], 7'd0} |
                                      {7'd0, bank_lo_reg[cur_status_reg[3:0]]};
                end
                else if (cur_status_reg[7:4] == mtep_pkg::CLS_CONTROL)
                begin
                    bank_hi_we = (first_data_reg == mtep_pkg::CTRL_BANK_MSB);
                    bank_lo_we = (first_data_reg == mtep_pkg::CTRL_BANK_LSB);
                end
            end
            default:
            begin
                phase_next = phase_c;
            end
        endcase

        // First data byte of a channel message.
        if (do_d1)
        begin
            wr_ch = d1_status[3:0];
            if (d1_status[7:4] == mtep_pkg::CLS_PROGRAM)
            begin
                prog_we    = 1'b1;
                phase_next = mtep_pkg::PH_DELTA;
            end
            else if (d1_status[7:4] == mtep_pkg::CLS_PRESSURE)
            begin
                phase_next = mtep_pkg::PH_DELTA;
            end
            else
            begin
                first_data_next = b;
                phase_next      = mtep_pkg::PH_DATA2;
            end
        end

        // Length byte of a meta or sysex event; its last byte starts any nonzero skip.
        if (do_len)
        begin
            len_acc = {varlen_next[24:0], b[6:0]};
            if (b[7])
            begin
                varlen_next = len_acc;
            end
            else
            begin
                varlen_next   = 32'd0;
                tempo_next    = 24'd0;
                tempo_on_next = len_meta && (meta_type_next == mtep_pkg::META_TEMPO) &&
                                (len_acc == mtep_pkg::TEMPO_LEN);
                skip_next     = len_acc;
                phase_next    = (len_acc == 32'd0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SKIP;
            end
        end
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= mtep_pkg::PH_DELTA;
            tick_reg        <= 32'd0;
            varlen_reg      <= 32'd0;
            last_status_reg <= 8'd0;
            last_valid_reg  <= 1'b0;
            cur_status_reg  <= 8'd0;
            first_data_reg  <= 8'd0;
            meta_type_reg   <= 8'd0;
            skip_reg        <= 32'd0;
            tempo_reg       <= 24'd0;
            tempo_on_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            tick_reg        <= tick_next;
            varlen_reg      <= varlen_next;
            last_status_reg <= last_status_next;
            last_valid_reg  <= last_valid_next;
            cur_status_reg  <= cur_status_next;
            first_data_reg  <= first_data_next;
            meta_type_reg   <= meta_type_next;
            skip_reg        <= skip_next;
            tempo_reg       <= tempo_next;
            tempo_on_reg    <= tempo_on_next;
        end
    end

    // Per-channel program and bank latches, cleared at reset and at track start.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                prog_reg[i]    <= 8'd0;
                bank_hi_reg[i] <= 8'd0;
                bank_lo_reg[i] <= 8'd0;
            end
        end
        else if (accept)
        begin
            if (start)
            begin
                for (int i = 0; i < 16; i++)
                begin
                    prog_reg[i]    <= 8'd0;
                    bank_hi_reg[i] <= 8'd0;
                    bank_lo_reg[i] <= 8'd0;
                end
            end
            else
            begin
                if (prog_we)
                begin
                    prog_reg[wr_ch] <= b;
                end
                if (bank_hi_we)
                begin
                    bank_hi_reg[wr_ch] <= b;
                end
                if (bank_lo_we)
                begin
                    bank_lo_reg[wr_ch] <= b;
                end
            end
        end
    end

    // Output and skid register control.
    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (accept && res_valid)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (accept && res_valid)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    // Master channel.
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {4'd0, out_reg.tempo, out_reg.bank, out_reg.program_num,
                       out_reg.channel, out_reg.note_on, out_reg.velocity, out_reg.note,
                       out_reg.tick};

    // Checks.
    `MTEP_ASSERT_NOW(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg, "skid register full while output register empty")
    `MTEP_ASSERT_NEXT(a_halt_holds, clk, rst_n, accept && !s_tuser[0] && phase_reg == mtep_pkg::PH_HALT, phase_reg == mtep_pkg::PH_HALT, "parser left halt without a track start")
    `MTEP_ASSERT_NEXT(a_start_leaves_halt, clk, rst_n, accept && s_tuser[0], phase_reg != mtep_pkg::PH_HALT, "track start byte did not clear halt")
    `MTEP_ASSERT_NOW(a_note_on_velocity, clk, rst_n, out_valid_reg && out_reg.note_on, out_reg.velocity != 8'd0 && out_reg.kind == mtep_pkg::KIND_NOTE, "note on flagged with zero velocity")

endmodule
